// File: hdl/sfm_pkg.sv
`default_nettype none

package sfm_pkg;

    // Default sizing, handed to the top level parameters.
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int COUNT_BITS_DEF    = 16;

    // Fixed field widths.
    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 32;
    localparam int ETYPE_W    = 16;
    localparam int PROTO_W    = 8;
    localparam int KIND_W     = 8;
    localparam int OUT_CNT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Index reduction for a table depth that is not a power of two.
    localparam int IDX_STEP_BITS   = 4;
    localparam int IDX_STEP_CYCLES = ADDR_W / IDX_STEP_BITS;
    localparam int IDX_CNT_W       = $clog2(IDX_STEP_CYCLES);

    // Header codes.
    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4    = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_ICMP        = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_UDP         = 8'd17;
    localparam logic [KIND_W-1:0]  ICMP_ECHO_REQUEST = 8'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_WINDOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOD_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS  = 3'd4;

    // Configuration reset values.
    localparam logic [15:0] RATE_LIMIT_RST      = 16'd1000;
    localparam logic [7:0]  RATE_WINDOW_RST     = 8'd1;
    localparam logic [15:0] FLOOD_THRESHOLD_RST = 16'd100;
    localparam logic [15:0] UDP_THRESHOLD_RST   = 16'd150;
    localparam logic [15:0] WINDOW_SECONDS_RST  = 16'd10;

    typedef struct packed {
        logic [15:0] rate_limit;
        logic [7:0]  rate_window_seconds;
        logic [15:0] flood_threshold;
        logic [15:0] udp_threshold;
        logic [15:0] window_seconds;
    } t_cfg;

    typedef struct packed {
        logic                 dropped;
        logic                 flood_alert;
        logic                 udp_alert;
        logic                 ping_alert;
        logic [OUT_CNT_W-1:0] window_count;
        logic [OUT_CNT_W-1:0] udp_window_count;
    } t_result;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INDEX,
        ST_UPDATE
    } t_state;

endpackage

`default_nettype wire

// File: hdl/sfm_index.sv
`default_nettype none

module sfm_index import sfm_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_src_addr,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_idx
);

    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic             r_done;
            logic [IDX_W-1:0] r_idx;

            // The remainder is the low address bits.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_idx <= i_src_addr[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_idx  = r_idx;
        end else begin : g_reduce
            localparam logic [IDX_W:0] DIVISOR = (IDX_W + 1)'(TABLE_ENTRIES);

            logic                 r_busy;
            logic                 r_done;
            logic [IDX_CNT_W-1:0] r_cnt;
            logic [ADDR_W-1:0]    r_shift;
            logic [IDX_W-1:0]     r_rem;
            logic [IDX_W-1:0]     n_rem;

            // Restoring remainder, a few address bits per cycle, MSB first.
            always_comb begin
                logic [IDX_W:0] v_part;
                n_rem = r_rem;
                for (int k = 0; k < IDX_STEP_BITS; k++) begin
                    v_part = {n_rem, r_shift[ADDR_W-1-k]};
                    if (v_part >= DIVISOR) begin
                        v_part = v_part - DIVISOR;
                    end
                    n_rem = v_part[IDX_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else if (i_start) begin
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else if (r_busy) begin
                    r_cnt  <= r_cnt + IDX_CNT_W'(1);
                    r_done <= (r_cnt == IDX_CNT_W'(IDX_STEP_CYCLES - 1));
                    r_busy <= (r_cnt != IDX_CNT_W'(IDX_STEP_CYCLES - 1));
                end else begin
                    r_done <= 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_shift <= i_src_addr;
                    r_rem   <= '0;
                end else if (r_busy) begin
                    r_shift <= r_shift << IDX_STEP_BITS;
                    r_rem   <= n_rem;
                end
            end

            assign o_done = r_done;
            assign o_idx  = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire

// File: hdl/sfm_table.sv
`default_nettype none

module sfm_table import sfm_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES),
    parameter int WORD_W        = 2 + 4 * ADDR_W + 3 * COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_ctrl         i_ctrl,
    input  logic [IDX_W-1:0]  i_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    output logic [WORD_W-1:0] o_rd_data,
    output logic              o_clr_busy
);

    logic [WORD_W-1:0] r_mem [TABLE_ENTRIES];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_clr_busy;
    logic [IDX_W-1:0]  r_clr_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    // Clearing pass after reset: one entry per cycle, valid bits go to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            r_clr_busy <= (r_clr_addr != IDX_W'(TABLE_ENTRIES - 1));
        end
    end

    // Write port shared by the clearing pass and the update.
    always_comb begin
        wr_en   = r_clr_busy || i_ctrl.wr_en;
        wr_addr = r_clr_busy ? r_clr_addr : i_addr;
        wr_data = r_clr_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

// File: hdl/sfm_update.sv
`default_nettype none

module sfm_update import sfm_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int WORD_W     = 2 + 4 * ADDR_W + 3 * COUNT_BITS
) (
    input  logic               i_ipv4,
    input  logic [ADDR_W-1:0]  i_src_addr,
    input  logic [PROTO_W-1:0] i_ip_protocol,
    input  logic [KIND_W-1:0]  i_icmp_kind,
    input  logic [TIME_W-1:0]  i_now_seconds,
    input  t_cfg               i_cfg,
    input  logic [WORD_W-1:0]  i_entry,
    output logic [WORD_W-1:0]  o_entry,
    output t_result            o_result
);

    typedef struct packed {
        logic                  udp_valid;
        logic                  valid;
        logic [ADDR_W-1:0]     tag;
        logic [TIME_W-1:0]     rate_start;
        logic [COUNT_BITS-1:0] rate_count;
        logic [TIME_W-1:0]     window_start;
        logic [COUNT_BITS-1:0] flood_count;
        logic [TIME_W-1:0]     udp_start;
        logic [COUNT_BITS-1:0] udp_count;
    } t_entry;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    t_entry                old_e;
    t_entry                new_e;
    logic                  fresh;
    logic [TIME_W-1:0]     rate_age;
    logic [TIME_W-1:0]     win_age;
    logic [TIME_W-1:0]     udp_age;
    logic [COUNT_BITS-1:0] rate_base;
    logic [COUNT_BITS-1:0] rate_next;
    logic [COUNT_BITS-1:0] pkt_inc;
    logic [COUNT_BITS-1:0] udp_inc;
    logic                  drop;

    assign old_e = t_entry'(i_entry);

    // Elapsed times wrap modulo the time width.
    always_comb begin
        fresh     = !(old_e.valid && (old_e.tag == i_src_addr));
        rate_age  = i_now_seconds - old_e.rate_start;
        win_age   = i_now_seconds - old_e.window_start;
        udp_age   = i_now_seconds - old_e.udp_start;
        pkt_inc   = sat_inc(old_e.flood_count);
        udp_inc   = sat_inc(old_e.udp_count);
        rate_base = old_e.rate_count;
        if (fresh || (rate_age > TIME_W'(i_cfg.rate_window_seconds))) begin
            rate_base = '0;
        end
        rate_next = sat_inc(rate_base);
        drop      = 32'(rate_next) > 32'(i_cfg.rate_limit);
    end

    // Rate limiter, then the flood and UDP windows of an accepted packet.
    always_comb begin
        new_e    = old_e;
        o_result = '0;

        new_e.valid      = 1'b1;
        new_e.tag        = i_src_addr;
        new_e.rate_count = rate_next;
        if (fresh || (rate_age > TIME_W'(i_cfg.rate_window_seconds))) begin
            new_e.rate_start = i_now_seconds;
        end
        if (fresh) begin
            new_e.udp_valid    = 1'b0;
            new_e.window_start = i_now_seconds;
            new_e.flood_count  = '0;
        end

        if (drop) begin
            o_result.dropped = 1'b1;
        end else begin
            // Packet-count window.
            if (fresh || (win_age > TIME_W'(i_cfg.window_seconds))) begin
                new_e.window_start = i_now_seconds;
                new_e.flood_count  = COUNT_BITS'(1);
            end else begin
                new_e.flood_count    = pkt_inc;
                o_result.flood_alert = 32'(pkt_inc) > 32'(i_cfg.flood_threshold);
            end
            o_result.window_count = OUT_CNT_W'(new_e.flood_count);

            o_result.ping_alert = (i_ip_protocol == PROTO_ICMP) &&
                                  (i_icmp_kind == ICMP_ECHO_REQUEST);

            // UDP window; its valid bit was cleared above for a new source.
            if (i_ip_protocol == PROTO_UDP) begin
                if (!new_e.udp_valid || (udp_age > TIME_W'(i_cfg.window_seconds))) begin
                    new_e.udp_valid = 1'b1;
                    new_e.udp_start = i_now_seconds;
                    new_e.udp_count = COUNT_BITS'(1);
                end else begin
                    new_e.udp_count    = udp_inc;
                    o_result.udp_alert = 32'(udp_inc) > 32'(i_cfg.udp_threshold);
                end
                o_result.udp_window_count = OUT_CNT_W'(new_e.udp_count);
            end
        end

        // A frame that is not IPv4 gives an all-zero word.
        if (!i_ipv4) begin
            o_result = '0;
        end
    end

    assign o_entry = WORD_W'(new_e);

endmodule

`default_nettype wire

// File: hdl/per_source_flood_monitor.sv
// Flow: an IPv4 word is indexed, read from the table and updated (ST_INDEX, then
// ST_UPDATE); for other depths than a power of two the index is reduced 4 bits per cycle.
// A new word is taken only in ST_IDLE, after the table read-modify-write and the
// handoff to the output register; a word that is not IPv4 skips the table.
// Reset: synchronous, active low; a clearing pass then zeroes the table entries,
// valid bits included, and no word is accepted until it ends.
`default_nettype none

module per_source_flood_monitor import sfm_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ETYPE_W-1:0]    i_ether_type,
    input  logic [ADDR_W-1:0]     i_src_addr,
    input  logic [PROTO_W-1:0]    i_ip_protocol,
    input  logic [KIND_W-1:0]     i_icmp_kind,
    input  logic [TIME_W-1:0]     i_now_seconds,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_dropped,
    output logic                  o_flood_alert,
    output logic                  o_udp_alert,
    output logic                  o_ping_alert,
    output logic [OUT_CNT_W-1:0]  o_window_count,
    output logic [OUT_CNT_W-1:0]  o_udp_window_count
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = 2 + 4 * ADDR_W + 3 * COUNT_BITS;

    t_state             r_state;
    t_state             n_state;
    t_cfg               r_cfg;
    logic               r_ipv4;
    logic [ADDR_W-1:0]  r_src_addr;
    logic [PROTO_W-1:0] r_ip_protocol;
    logic [KIND_W-1:0]  r_icmp_kind;
    logic [TIME_W-1:0]  r_now_seconds;
    logic               r_out_valid;
    t_result            r_result;

    logic               in_ready;
    logic               accept;
    logic               in_ipv4;
    logic               out_free;
    logic               load_out;
    logic               idx_start;
    logic               idx_done;
    logic [IDX_W-1:0]   idx;
    t_mem_ctrl          mem_ctrl;
    logic               clr_busy;
    logic [WORD_W-1:0]  rd_entry;
    logic [WORD_W-1:0]  wr_entry;
    t_result            result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_limit          <= RATE_LIMIT_RST;
            r_cfg.rate_window_seconds <= RATE_WINDOW_RST;
            r_cfg.flood_threshold     <= FLOOD_THRESHOLD_RST;
            r_cfg.udp_threshold       <= UDP_THRESHOLD_RST;
            r_cfg.window_seconds      <= WINDOW_SECONDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RATE_LIMIT:      r_cfg.rate_limit          <= i_cfg_data;
                CFG_RATE_WINDOW:     r_cfg.rate_window_seconds <= i_cfg_data[7:0];
                CFG_FLOOD_THRESHOLD: r_cfg.flood_threshold     <= i_cfg_data;
                CFG_UDP_THRESHOLD:   r_cfg.udp_threshold       <= i_cfg_data;
                CFG_WINDOW_SECONDS:  r_cfg.window_seconds      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ipv4  = (i_ether_type == ETHERTYPE_IPV4);
    assign out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = in_ipv4 ? ST_INDEX : ST_UPDATE;
                end
            end
            ST_INDEX: begin
                if (idx_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready       = (r_state == ST_IDLE) && !clr_busy;
        accept         = i_in_valid && in_ready;
        idx_start      = accept && in_ipv4;
        mem_ctrl.rd_en = (r_state == ST_INDEX) && idx_done;
        load_out       = (r_state == ST_UPDATE) && out_free;
        mem_ctrl.wr_en = load_out && r_ipv4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the accepted word while it works through the table.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ipv4        <= in_ipv4;
            r_src_addr    <= i_src_addr;
            r_ip_protocol <= i_ip_protocol;
            r_icmp_kind   <= i_icmp_kind;
            r_now_seconds <= i_now_seconds;
        end
    end

    sfm_index #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (idx_start),
        .i_src_addr (i_src_addr),
        .o_done     (idx_done),
        .o_idx      (idx)
    );

    sfm_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .WORD_W        (WORD_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (mem_ctrl),
        .i_addr     (idx),
        .i_wr_data  (wr_entry),
        .o_rd_data  (rd_entry),
        .o_clr_busy (clr_busy)
    );

    sfm_update #(
        .COUNT_BITS (COUNT_BITS),
        .WORD_W     (WORD_W)
    ) u_update (
        .i_ipv4        (r_ipv4),
        .i_src_addr    (r_src_addr),
        .i_ip_protocol (r_ip_protocol),
        .i_icmp_kind   (r_icmp_kind),
        .i_now_seconds (r_now_seconds),
        .i_cfg         (r_cfg),
        .i_entry       (rd_entry),
        .o_entry       (wr_entry),
        .o_result      (result)
    );

    // Output register; frees the input side while a word waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_result <= result;
        end
    end

    assign o_in_ready         = in_ready;
    assign o_out_valid        = r_out_valid;
    assign o_dropped          = r_result.dropped;
    assign o_flood_alert      = r_result.flood_alert;
    assign o_udp_alert        = r_result.udp_alert;
    assign o_ping_alert       = r_result.ping_alert;
    assign o_window_count     = r_result.window_count;
    assign o_udp_window_count = r_result.udp_window_count;

    // An update never collides with the clearing pass.
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctrl.wr_en |-> !clr_busy)
        else $error("table update during clearing pass");

    // An IPv4 update entered from the index state follows a table read in the previous cycle.
    a_read_before_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && r_ipv4 && $past(r_state) == ST_INDEX)
        |-> $past(mem_ctrl.rd_en))
        else $error("update without a table read");

    // A new word appears only from the update state.
    a_load_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_UPDATE)
        else $error("output loaded outside update");

    // An accepted word always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != ST_IDLE)
        else $error("accepted word lost");

endmodule

`default_nettype wire
